@@ design/planar_pose_compose_relative_defines.svh @@
// ---------------------------------------------------------------------------
// Planar pose compose/relative - assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PLANAR_POSE_COMPOSE_RELATIVE_DEFINES_SVH
`define PLANAR_POSE_COMPOSE_RELATIVE_DEFINES_SVH

// same-cycle implication
`define PPCR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppcr same-cycle check failed");

// next-cycle implication
`define PPCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppcr next-cycle check failed");

`endif

@@ design/ppcr_pkg.sv @@
// ---------------------------------------------------------------------------
// ppcr_pkg
// Constants, payload types and the CORDIC angle table for the pose unit.
// ---------------------------------------------------------------------------
package ppcr_pkg;

    // rotation stage count, capped at the table length
    localparam int CordicStages = 16;
    localparam int MaxStages    = 24;
    localparam int NumStages    = (CordicStages < MaxStages) ? CordicStages : MaxStages;
    localparam int ShiftW       = $clog2(MaxStages);

    // CORDIC gain reciprocal, Q2.30
    localparam logic signed [31:0] GainQ30 = 32'sd652032874;

    // position limits, Q8.16
    localparam int PosMax = 8388607;
    localparam int PosMin = -8388608;

    // commands
    localparam logic CmdCompose  = 1'b0;
    localparam logic CmdRelative = 1'b1;

    // rotating vector: x = cos, y = sin, z = residual angle (2^-32 turn)
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } ppcr_vec_t;

    // operands carried beside the rotator
    typedef struct packed {
        logic               cmd;
        logic signed [24:0] px;
        logic signed [24:0] py;
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic        [15:0] heading;
    } ppcr_side_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input logic [ShiftW-1:0] idx);
        logic signed [31:0] a;
        unique case (idx)
            5'd0:    a = 32'sh20000000;
            5'd1:    a = 32'sh12E4051E;
            5'd2:    a = 32'sh09FB385B;
            5'd3:    a = 32'sh051111D4;
            5'd4:    a = 32'sh028B0D43;
            5'd5:    a = 32'sh0145D7E1;
            5'd6:    a = 32'sh00A2F61E;
            5'd7:    a = 32'sh00517C55;
            5'd8:    a = 32'sh0028BE53;
            5'd9:    a = 32'sh00145F2F;
            5'd10:   a = 32'sh000A2F98;
            5'd11:   a = 32'sh000517CC;
            5'd12:   a = 32'sh00028BE6;
            5'd13:   a = 32'sh000145F3;
            5'd14:   a = 32'sh0000A2FA;
            5'd15:   a = 32'sh0000517D;
            5'd16:   a = 32'sh000028BE;
            5'd17:   a = 32'sh0000145F;
            5'd18:   a = 32'sh00000A30;
            5'd19:   a = 32'sh00000518;
            5'd20:   a = 32'sh0000028C;
            5'd21:   a = 32'sh00000146;
            5'd22:   a = 32'sh000000A3;
            5'd23:   a = 32'sh00000051;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

endpackage

@@ design/ppcr_cordic_stage.sv @@
// ---------------------------------------------------------------------------
// ppcr_cordic_stage
// One registered CORDIC rotation step; side operands ride along unchanged.
// ---------------------------------------------------------------------------
module ppcr_cordic_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  ppcr_pkg::ppcr_vec_t              in_vec,
    input  ppcr_pkg::ppcr_side_t             in_side,
    input  logic [ppcr_pkg::ShiftW-1:0]      shift,
    input  logic signed [31:0]               angle,
    output logic                             out_valid,
    output ppcr_pkg::ppcr_vec_t              out_vec,
    output ppcr_pkg::ppcr_side_t             out_side
);

    logic                  valid_reg;
    ppcr_pkg::ppcr_vec_t   vec_reg;
    ppcr_pkg::ppcr_side_t  side_reg;
    ppcr_pkg::ppcr_vec_t   vec_next;
    logic signed [31:0]    cur_x;
    logic signed [31:0]    cur_y;
    logic signed [31:0]    dx;
    logic signed [31:0]    dy;

    // rotate toward zero residual angle
    always_comb begin
        cur_x = in_vec.x;
        cur_y = in_vec.y;
        dx    = cur_y >>> shift;
        dy    = cur_x >>> shift;
        if (!in_vec.z[31]) begin
            vec_next.x = cur_x - dx;
            vec_next.y = cur_y + dy;
            vec_next.z = in_vec.z - angle;
        end else begin
            vec_next.x = cur_x + dx;
            vec_next.y = cur_y - dy;
            vec_next.z = in_vec.z + angle;
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

@@ design/planar_pose_compose_relative.sv @@
// ---------------------------------------------------------------------------
// planar_pose_compose_relative
// SE(2) pose compose / relative pose with pipelined CORDIC sine and cosine.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | cmd, base pose, other pose
//  m_      | out | m_valid / m_ready  | out_x, out_y, out_heading, saturated
//
//  One transfer per cycle sustained while m_ready is held. Registers in order:
//  input register, one register per CORDIC rotation, product register,
//  round register, add/clip output register.
//  Reset clears only the per-stage valid bits.
//  Each stage advances when the one after it is empty or moving, so bubbles
//  close up behind a stalled output and nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "planar_pose_compose_relative_defines.svh"

module planar_pose_compose_relative (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [23:0] s_base_x,
    input  logic signed [23:0] s_base_y,
    input  logic signed [15:0] s_base_heading,
    input  logic signed [23:0] s_other_x,
    input  logic signed [23:0] s_other_y,
    input  logic signed [15:0] s_other_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_out_x,
    output logic signed [23:0] m_out_y,
    output logic signed [15:0] m_out_heading,
    output logic               m_saturated
);

    localparam int N = ppcr_pkg::NumStages;

    // stage chain: index 0 is the input register, 1..N the rotations
    logic                  cv     [0:N];
    ppcr_pkg::ppcr_vec_t   c_vec  [0:N];
    ppcr_pkg::ppcr_side_t  c_side [0:N];
    logic                  en_c   [0:N+1];

    logic                  s0_valid_reg;
    ppcr_pkg::ppcr_vec_t   s0_vec_reg;
    ppcr_pkg::ppcr_side_t  s0_side_reg;
    ppcr_pkg::ppcr_vec_t   s0_vec_next;
    ppcr_pkg::ppcr_side_t  s0_side_next;
    logic signed [31:0]    z_raw;

    logic                  p_valid_reg;
    ppcr_pkg::ppcr_side_t  p_side_reg;
    logic signed [56:0]    pcx_reg, psy_reg, psx_reg, pcy_reg;
    logic signed [56:0]    pcx_next, psy_next, psx_next, pcy_next;

    logic                  r_valid_reg;
    ppcr_pkg::ppcr_side_t  r_side_reg;
    logic signed [27:0]    rnd_x_reg, rnd_y_reg;
    logic signed [27:0]    rnd_x_next, rnd_y_next;
    logic signed [57:0]    sum_x, sum_y;

    logic                  o_valid_reg;
    logic signed [23:0]    out_x_reg, out_y_reg;
    logic        [15:0]    out_heading_reg;
    logic                  sat_reg;
    logic signed [23:0]    out_x_next, out_y_next;
    logic                  sat_next;
    logic signed [28:0]    fx, fy;

    logic en_p, en_r, en_o;

    // advance enables, back to front
    assign en_o      = !o_valid_reg || m_ready;
    assign en_r      = !r_valid_reg || en_o;
    assign en_p      = !p_valid_reg || en_r;
    assign en_c[N+1] = en_p;

    genvar k;
    generate
        for (k = 0; k <= N; k++) begin : g_en
            assign en_c[k] = !cv[k] || en_c[k+1];
        end
    endgenerate

    assign s_ready = en_c[0];

    // input stage: quadrant fold of the heading and operand setup
    always_comb begin
        z_raw         = {s_base_heading, 16'h0000};
        s0_vec_next.y = '0;
        if (s_base_heading > 16'sd16384 || s_base_heading < -16'sd16384) begin
            // shift by half a turn and start from the negated gain
            s0_vec_next.z = {~z_raw[31], z_raw[30:0]};
            s0_vec_next.x = -ppcr_pkg::GainQ30;
        end else begin
            s0_vec_next.z = z_raw;
            s0_vec_next.x = ppcr_pkg::GainQ30;
        end

        s0_side_next.cmd = s_cmd;
        if (s_cmd == ppcr_pkg::CmdRelative) begin
            s0_side_next.px      = 25'(s_other_x) - 25'(s_base_x);
            s0_side_next.py      = 25'(s_other_y) - 25'(s_base_y);
            s0_side_next.ax      = '0;
            s0_side_next.ay      = '0;
            s0_side_next.heading = s_other_heading - s_base_heading;
        end else begin
            s0_side_next.px      = 25'(s_other_x);
            s0_side_next.py      = 25'(s_other_y);
            s0_side_next.ax      = s_base_x;
            s0_side_next.ay      = s_base_y;
            s0_side_next.heading = s_base_heading + s_other_heading;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en_c[0]) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c[0]) begin
            s0_vec_reg  <= s0_vec_next;
            s0_side_reg <= s0_side_next;
        end
    end

    assign cv[0]     = s0_valid_reg;
    assign c_vec[0]  = s0_vec_reg;
    assign c_side[0] = s0_side_reg;

    // CORDIC rotation stages
    generate
        for (k = 1; k <= N; k++) begin : g_rot
            localparam int unsigned StageIdx = k - 1;
            ppcr_cordic_stage u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en_c[k]),
                .in_valid  (cv[k-1]),
                .in_vec    (c_vec[k-1]),
                .in_side   (c_side[k-1]),
                .shift     (StageIdx[ppcr_pkg::ShiftW-1:0]),
                .angle     (ppcr_pkg::atan_turn(StageIdx[ppcr_pkg::ShiftW-1:0])),
                .out_valid (cv[k]),
                .out_vec   (c_vec[k]),
                .out_side  (c_side[k])
            );
        end
    endgenerate

    // product stage: cos/sin times position operands
    always_comb begin
        pcx_next = 57'(c_vec[N].x) * 57'(c_side[N].px);
        psy_next = 57'(c_vec[N].y) * 57'(c_side[N].py);
        psx_next = 57'(c_vec[N].y) * 57'(c_side[N].px);
        pcy_next = 57'(c_vec[N].x) * 57'(c_side[N].py);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en_p) begin
            p_valid_reg <= cv[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p) begin
            pcx_reg    <= pcx_next;
            psy_reg    <= psy_next;
            psx_reg    <= psx_next;
            pcy_reg    <= pcy_next;
            p_side_reg <= c_side[N];
        end
    end

    // sum stage: combine products and round Q2.30 x Q8.16 back to Q8.16
    always_comb begin
        if (p_side_reg.cmd == ppcr_pkg::CmdRelative) begin
            sum_x = 58'(pcx_reg) + 58'(psy_reg);
            sum_y = 58'(pcy_reg) - 58'(psx_reg);
        end else begin
            sum_x = 58'(pcx_reg) - 58'(psy_reg);
            sum_y = 58'(psx_reg) + 58'(pcy_reg);
        end
        rnd_x_next = 28'((sum_x + 58'sd536870912) >>> 30);
        rnd_y_next = 28'((sum_y + 58'sd536870912) >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en_r) begin
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_r) begin
            rnd_x_reg  <= rnd_x_next;
            rnd_y_reg  <= rnd_y_next;
            r_side_reg <= p_side_reg;
        end
    end

    // output stage: add base offset and clip
    always_comb begin
        fx       = 29'(rnd_x_reg) + 29'(r_side_reg.ax);
        fy       = 29'(rnd_y_reg) + 29'(r_side_reg.ay);
        sat_next = 1'b0;
        if (fx > 29'(ppcr_pkg::PosMax)) begin
            out_x_next = 24'(ppcr_pkg::PosMax);
            sat_next   = 1'b1;
        end else if (fx < 29'(ppcr_pkg::PosMin)) begin
            out_x_next = 24'(ppcr_pkg::PosMin);
            sat_next   = 1'b1;
        end else begin
            out_x_next = fx[23:0];
        end
        if (fy > 29'(ppcr_pkg::PosMax)) begin
            out_y_next = 24'(ppcr_pkg::PosMax);
            sat_next   = 1'b1;
        end else if (fy < 29'(ppcr_pkg::PosMin)) begin
            out_y_next = 24'(ppcr_pkg::PosMin);
            sat_next   = 1'b1;
        end else begin
            out_y_next = fy[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en_o) begin
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_o) begin
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_heading_reg <= r_side_reg.heading;
            sat_reg         <= sat_next;
        end
    end

    assign m_valid       = o_valid_reg;
    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_out_heading = out_heading_reg;
    assign m_saturated   = sat_reg;

    // a transfer on the input lands in the input register
    `PPCR_ASSERT_NEXT(a_in_lands, s_valid && s_ready, s0_valid_reg)
    // input back-pressure only when the whole pipe is full
    `PPCR_ASSERT_NOW(a_full_stall, !s_ready,
        cv[N] && p_valid_reg && r_valid_reg && o_valid_reg && !m_ready)
    // a held output keeps the item behind it
    `PPCR_ASSERT_NEXT(a_round_held, o_valid_reg && !m_ready && r_valid_reg, r_valid_reg)
    // saturation flag implies a clipped coordinate
    `PPCR_ASSERT_NOW(a_sat_clip, m_valid && m_saturated,
        m_out_x == 24'sh7FFFFF || m_out_x == -24'sh800000 ||
        m_out_y == 24'sh7FFFFF || m_out_y == -24'sh800000)

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench - planar_pose_compose_relative
// Drives base/other pose pairs through both commands, predicts each result
// with a bit-exact CORDIC rotation model and checks every output transfer in
// order, under random idling on both channels and one long output stall.
// ---------------------------------------------------------------------------
module testbench;

    localparam int NumRandom  = 600;
    localparam int IdleLimit  = 3000;   // cycles with no transfer before giving up
    localparam int DrainWait  = 40;     // extra wait once every result is checked
    localparam int HoldAfter  = 150;    // input transfers before the long stall
    localparam int HoldCycles = 400;

    typedef struct {
        logic               cmd;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic signed [15:0] bh;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [15:0] oh;
    } pose_pair_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] heading;
        logic               sat;
    } pose_out_t;

    // Bit-exact SE(2) transform predictor plus in-order result store
    class pose_scoreboard;
        pose_out_t pose_queue[$];
        int        errors;
        int        accepted;
        int        checked;
        int        n_compose;
        int        n_relative;
        int        n_clipped;
        // atan(2^-i) in units of 2^-32 turn
        longint    step_angle[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

        // cos/sin of a binary angle, Q2.30, by CORDIC rotation
        function void heading_trig(input logic signed [15:0] h,
                                   output longint c, output longint s);
            longint x, y, z, dx, dy;
            int     i;
            z = longint'(h) * 65536;
            x = longint'(ppcr_pkg::GainQ30);
            y = 0;
            // fold the outer half-turns onto the start vector
            if (h > 16384) begin
                z = z - (64'sd1 <<< 31);
                x = -x;
            end else if (h < -16384) begin
                z = z + (64'sd1 <<< 31);
                x = -x;
            end
            for (i = 0; i < ppcr_pkg::CordicStages && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_angle[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_angle[i];
                end
            end
            c = x;
            s = y;
        endfunction

        function longint round_q30(input longint v);
            return (v + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function longint clip_pos(input longint v, inout logic sat);
            if (v > ppcr_pkg::PosMax) begin
                sat = 1'b1;
                return ppcr_pkg::PosMax;
            end
            if (v < ppcr_pkg::PosMin) begin
                sat = 1'b1;
                return ppcr_pkg::PosMin;
            end
            return v;
        endfunction

        function pose_out_t transform_pose(input pose_pair_t p);
            pose_out_t  r;
            longint     c, s, rx, ry, dx, dy;
            logic       sat;
            heading_trig(p.bh, c, s);
            sat = 1'b0;
            if (p.cmd == ppcr_pkg::CmdCompose) begin
                rx = longint'(p.bx) + round_q30(c * longint'(p.ox) - s * longint'(p.oy));
                ry = longint'(p.by) + round_q30(s * longint'(p.ox) + c * longint'(p.oy));
                r.heading = p.bh + p.oh;
            end else begin
                // difference kept at full width before rotating
                dx = longint'(p.ox) - longint'(p.bx);
                dy = longint'(p.oy) - longint'(p.by);
                rx = round_q30(c * dx + s * dy);
                ry = round_q30(c * dy - s * dx);
                r.heading = p.oh - p.bh;
            end
            r.x   = 24'(clip_pos(rx, sat));
            r.y   = 24'(clip_pos(ry, sat));
            r.sat = sat;
            return r;
        endfunction

        function void note_input(input pose_pair_t p);
            pose_out_t r;
            r = transform_pose(p);
            pose_queue.push_back(r);
            accepted++;
            if (p.cmd == ppcr_pkg::CmdCompose) n_compose++;
            else n_relative++;
            if (r.sat) n_clipped++;
        endfunction

        function void check_result(input pose_out_t got);
            pose_out_t want;
            if (pose_queue.size() == 0) begin
                $display("%0t: result with nothing outstanding: x=%0d y=%0d h=%0d sat=%0b",
                         $time, got.x, got.y, got.heading, got.sat);
                errors++;
                return;
            end
            want = pose_queue.pop_front();
            checked++;
            if (got.x !== want.x) begin
                $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.heading !== want.heading) begin
                $display("%0t: out_heading expected %0d actual %0d",
                         $time, want.heading, got.heading);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic signed [23:0] s_base_x;
    logic signed [23:0] s_base_y;
    logic signed [15:0] s_base_heading;
    logic signed [23:0] s_other_x;
    logic signed [23:0] s_other_y;
    logic signed [15:0] s_other_heading;
    logic               m_valid;
    logic               m_ready;
    logic signed [23:0] m_out_x;
    logic signed [23:0] m_out_y;
    logic signed [15:0] m_out_heading;
    logic               m_saturated;

    pose_scoreboard sb = new();
    int             idle_cycles = 0;

    planar_pose_compose_relative u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_base_x        (s_base_x),
        .s_base_y        (s_base_y),
        .s_base_heading  (s_base_heading),
        .s_other_x       (s_other_x),
        .s_other_y       (s_other_y),
        .s_other_heading (s_other_heading),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_heading   (m_out_heading),
        .m_saturated     (m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [23:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 24'($urandom);
        if (roll < 85) return 24'(int'($urandom_range(0, 524288)) - 262144);
        if (roll < 93) return 24'(ppcr_pkg::PosMax - int'($urandom_range(0, 255)));
        return 24'(ppcr_pkg::PosMin + int'($urandom_range(0, 255)));
    endfunction

    // headings: mostly anywhere, sometimes on the quadrant folds, at zero or at half a turn
    function automatic logic signed [15:0] pick_heading();
        if ($urandom_range(0, 99) < 80) return 16'($urandom);
        case ($urandom_range(0, 6))
            0:       return 16'sd0;
            1:       return 16'sd16384;
            2:       return 16'sd16385;
            3:       return -16'sd16384;
            4:       return -16'sd16385;
            5:       return 16'sd32767;
            default: return -16'sd32768;
        endcase
    endfunction

    function automatic pose_pair_t make_pose(input logic cmd,
            input int bx, input int by, input int bh,
            input int ox, input int oy, input int oh);
        pose_pair_t p;
        p.cmd = cmd;
        p.bx  = 24'(bx);
        p.by  = 24'(by);
        p.bh  = 16'(bh);
        p.ox  = 24'(ox);
        p.oy  = 24'(oy);
        p.oh  = 16'(oh);
        return p;
    endfunction

    // one input transfer, optionally preceded by an idle gap
    task automatic send_pose(input pose_pair_t p, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= p.cmd;
        s_base_x        <= p.bx;
        s_base_y        <= p.by;
        s_base_heading  <= p.bh;
        s_other_x       <= p.ox;
        s_other_y       <= p.oy;
        s_other_heading <= p.oh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // transfer monitor, result check and idle watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(make_pose(s_cmd, int'(s_base_x), int'(s_base_y),
                                        int'(s_base_heading), int'(s_other_x),
                                        int'(s_other_y), int'(s_other_heading)));
            if (m_valid && m_ready)
                sb.check_result('{m_out_x, m_out_y, m_out_heading, m_saturated});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IdleLimit, sb.pose_queue.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // output side: random back-pressure plus one long stall to fill the pipe
    initial begin
        int  run_len;
        int  gap_len;
        bit  held;
        m_ready <= 1'b0;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sb.accepted >= HoldAfter) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            gap_len = idle_length();
            if (gap_len > 0) begin
                m_ready <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
    end

    // input side: reset, directed corners, random traffic, drain
    initial begin
        pose_pair_t corner_cases[$];
        pose_pair_t p;
        int         i;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_cmd           <= ppcr_pkg::CmdCompose;
        s_base_x        <= '0;
        s_base_y        <= '0;
        s_base_heading  <= '0;
        s_other_x       <= '0;
        s_other_y       <= '0;
        s_other_heading <= '0;

        // zero, unit vectors on each side of the quadrant folds
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, 0, 0, 0, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 100, -200, 0, 65536, 0, 10));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, 16384, 65536, 32768, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, 16385, 65536, 32768, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, -16384,
                                         65536, -32768, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, -16385,
                                         65536, -32768, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 5, 7, -32768,
                                         65536, 131072, 1));
        // heading wrap in compose
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, 32767, 0, 0, 32767));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, 0, -32768, 0, 0, -32768));
        // clipping in compose, both signs and both axes
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, ppcr_pkg::PosMax, 0, 0,
                                         ppcr_pkg::PosMax, 0, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, ppcr_pkg::PosMin, 0, 0,
                                         ppcr_pkg::PosMin, 0, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose, 0, ppcr_pkg::PosMax, 0,
                                         0, ppcr_pkg::PosMax, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 32767,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 32767));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdCompose,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, -32768,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, -32768));
        // relative: zero, full-width differences, heading wrap
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative, 0, 0, 0, 0, 0, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, 0,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 0,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative, 0, 0, 32767, 0, 0, -32768));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative, 1000, -1000, 16385,
                                         70000, 50000, 0));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative, -5000, 3000, -32768,
                                         65536, -65536, 16384));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 32767,
                                         ppcr_pkg::PosMax, ppcr_pkg::PosMax, 32767));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, -32768,
                                         ppcr_pkg::PosMin, ppcr_pkg::PosMin, -32768));
        corner_cases.push_back(make_pose(ppcr_pkg::CmdRelative, ppcr_pkg::PosMin, 0, -16385,
                                         ppcr_pkg::PosMax, 0, 16385));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_cases[k])
            send_pose(corner_cases[k], 1'b0);

        for (i = 0; i < NumRandom; i++) begin
            p.cmd = ($urandom_range(0, 1) != 0) ? ppcr_pkg::CmdRelative
                                                : ppcr_pkg::CmdCompose;
            p.bx  = pick_position();
            p.by  = pick_position();
            p.bh  = pick_heading();
            p.ox  = pick_position();
            p.oy  = pick_position();
            p.oh  = pick_heading();
            // one stretch of back-to-back input
            send_pose(p, (i >= 300 && i < 400));
        end
        s_valid <= 1'b0;

        while (sb.pose_queue.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        $display("Checked %0d results: %0d compose, %0d relative, %0d clipped,",
                 sb.checked, sb.n_compose, sb.n_relative, sb.n_clipped);
        $display("with random idling on both sides and a %0d-cycle output stall.",
                 HoldCycles);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ppcr_pkg.sv
design/ppcr_cordic_stage.sv
design/planar_pose_compose_relative.sv
tb/sv/testbench.sv
